// File: src/blzss_pkg.sv
package blzss_pkg;

  typedef logic [7:0] byte_t;

  // Parser phase codes
  typedef logic [1:0] phase_t;
  localparam phase_t PH_FLAG  = 2'd0;
  localparam phase_t PH_ITEM  = 2'd1;
  localparam phase_t PH_TOKEN = 2'd2;

  localparam int unsigned ITEMS_PER_FLAG = 8;
  localparam int unsigned LEN_BIAS       = 3;
  localparam int unsigned DIST_BIAS      = 3;

  typedef logic [3:0] bits_left_t;
  // Remaining copy bytes minus one: up to 15 + LEN_BIAS - 1
  typedef logic [4:0] count_t;
  localparam count_t MAX_COUNT = count_t'(15 + LEN_BIAS - 1);
  // Distance field plus bias: up to 4095 + DIST_BIAS
  typedef logic [12:0] dist_t;

endpackage

// File: src/blzss_in_if.sv
interface blzss_in_if import blzss_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: src/blzss_out_if.sv
interface blzss_out_if import blzss_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_last;
  logic  truncated;
  logic  stream_done;

  modport source (output valid, output out_byte, output run_last, output truncated,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input run_last, input truncated,
                  input stream_done, output ready);
endinterface

// File: src/backward_lzss_decompressor_top.sv
// Backward LZSS decompressor. Compressed bytes enter on din in reading order
// (stream end toward start), one request each; decompressed bytes leave on
// dout in production order. A flag byte gives no output, nor does a first
// token byte unless in_last marks it, when a truncated marker leaves; a
// literal gives one byte. A second token byte starts a copy of 3 to 18 bytes
// out of the history RAM: the block first reads the RAM, then writes and
// emits one copied byte at a time, stalling while dout stalls, and din is
// not ready meanwhile. The history RAM has one read and one write port, so
// a copy moves through it one byte at a time. A result still
// waiting in the dout register holds off every din request, flag bytes and
// first token bytes included, until dout takes it; in_last on any byte
// restarts the parser and the write pointer for the next stream, keeping
// history. History is not cleared after reset: a copy that reaches an entry
// never written since reset returns undefined data.
module backward_lzss_decompressor_top import blzss_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic         clk,
  input  logic         rst,
  blzss_in_if.sink     din,
  blzss_out_if.source  dout
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(HISTORY_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]    state;
  phase_t        phase;
  byte_t         flag_bits;
  bits_left_t    bits_left;
  byte_t         pending_high;
  logic [AW-1:0] wp;
  logic [AW-1:0] ra;
  count_t        count;
  logic          tok_last;

  byte_t         hist [HISTORY_DEPTH];
  byte_t         rdata;

  logic          slot_free;
  logic          take;
  logic          fin;
  logic          advance;
  dist_t         copy_dist;
  logic [AW:0]   wp_w;
  logic [AW:0]   dist_w;
  logic [AW-1:0] ra_start;
  bits_left_t    bits_dec;

  assign slot_free = !dout.valid || dout.ready;
  assign din.ready = (state == S_IDLE) && slot_free;
  assign take      = din.valid && din.ready;
  assign fin       = (count == '0);
  assign advance   = (state == S_WRITE) && slot_free;

  // Start of the copy: write pointer minus distance, wrapped into the RAM.
  assign copy_dist = {pending_high[3:0], din.in_byte} + dist_t'(DIST_BIAS);
  assign wp_w     = {1'b0, wp};
  assign dist_w   = (AW+1)'(copy_dist);
  assign ra_start = (wp_w >= dist_w) ? AW'(wp_w - dist_w) : AW'(wp_w + DEPTH_W - dist_w);

  assign bits_dec = (bits_left != '0) ? bits_left - 4'd1 : bits_left;

  // History RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (take && phase == PH_ITEM && !flag_bits[7]) begin
      hist[wp] <= din.in_byte;
    end else if (advance) begin
      hist[wp] <= rdata;
    end
    if ((state == S_READ) || (advance && !fin)) begin
      rdata <= hist[ra];
    end
  end

  // Control and parser
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_FLAG;
      flag_bits    <= '0;
      bits_left    <= '0;
      pending_high <= '0;
      wp           <= '0;
      count        <= '0;
      tok_last     <= 1'b0;
      dout.valid   <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        dout.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (phase)
              PH_FLAG: begin
                flag_bits <= din.in_byte;
                bits_left <= bits_left_t'(ITEMS_PER_FLAG);
                phase     <= PH_ITEM;
              end
              PH_ITEM: begin
                if (!flag_bits[7]) begin
                  // literal: emit and store
                  dout.valid <= 1'b1;
                  wp         <= (wp == LAST_IDX) ? '0 : wp + 1'b1;
                  flag_bits  <= flag_bits << 1;
                  bits_left  <= bits_dec;
                  phase      <= (bits_dec == '0) ? PH_FLAG : PH_ITEM;
                end else begin
                  // hold the first token byte
                  pending_high <= din.in_byte;
                  phase        <= PH_TOKEN;
                  if (din.in_last) begin
                    dout.valid <= 1'b1;
                  end
                end
              end
              PH_TOKEN: begin
                ra        <= ra_start;
                count     <= count_t'(pending_high[7:4]) + count_t'(LEN_BIAS - 1);
                tok_last  <= din.in_last;
                flag_bits <= flag_bits << 1;
                bits_left <= bits_dec;
                phase     <= (bits_dec == '0) ? PH_FLAG : PH_ITEM;
                state     <= S_READ;
              end
              default: begin
                phase <= PH_FLAG;
              end
            endcase
            if (din.in_last) begin
              // restart the parser; a copy resets the write pointer at its end
              flag_bits    <= '0;
              bits_left    <= '0;
              phase        <= PH_FLAG;
              pending_high <= '0;
              if (phase != PH_TOKEN) begin
                wp <= '0;
              end
            end
          end
        end
        S_READ: begin
          ra    <= (ra == LAST_IDX) ? '0 : ra + 1'b1;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (advance) begin
            dout.valid <= 1'b1;
            if (fin) begin
              wp    <= tok_last ? '0 : ((wp == LAST_IDX) ? '0 : wp + 1'b1);
              state <= S_IDLE;
            end else begin
              wp    <= (wp == LAST_IDX) ? '0 : wp + 1'b1;
              ra    <= (ra == LAST_IDX) ? '0 : ra + 1'b1;
              count <= count - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take && phase == PH_ITEM) begin
      if (!flag_bits[7]) begin
        dout.out_byte    <= din.in_byte;
        dout.run_last    <= 1'b1;
        dout.truncated   <= 1'b0;
        dout.stream_done <= din.in_last;
      end else if (din.in_last) begin
        dout.out_byte    <= '0;
        dout.run_last    <= 1'b1;
        dout.truncated   <= 1'b1;
        dout.stream_done <= 1'b1;
      end
    end else if (advance) begin
      dout.out_byte    <= rdata;
      dout.run_last    <= fin;
      dout.truncated   <= 1'b0;
      dout.stream_done <= fin && tok_last;
    end
  end

`ifndef SYNTHESIS
  a_done_is_run_last: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.stream_done |-> dout.run_last)
    else $error("stream_done without run_last");

  a_trunc_form: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.truncated |-> dout.stream_done && dout.out_byte == '0)
    else $error("truncated result malformed");

  a_restart_wp: assert property (@(posedge clk) disable iff (rst)
    take && din.in_last && phase != PH_TOKEN |=> wp == '0 && phase == PH_FLAG)
    else $error("parser not restarted after last byte");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> count <= MAX_COUNT)
    else $error("copy count out of range");
`endif

endmodule

// File: verif/tb_backward_lzss_decompressor_top.sv
`timescale 1ns / 100ps

module tb_backward_lzss_decompressor_top;
  import blzss_pkg::*;

  localparam int unsigned HISTORY_DEPTH  = 8192;
  localparam int unsigned MAX_DIST       = 4095 + DIST_BIAS;
  // Distance - 3 needs bit 11 from here on
  localparam int unsigned FAR_DIST       = 2048 + DIST_BIAS;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 240;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned IDLE_PCT       = 11;

  // One compressed byte on its way in; a drain entry holds the sender back
  // until every predicted byte has been seen on dout.
  typedef struct {
    byte_t data;
    logic  last;
    logic  drain;
  } request_t;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
    logic  truncated;
    logic  stream_done;
  } decoded_t;

  logic clk;
  logic rst = 1'b1;

  blzss_in_if  din_if ();
  blzss_out_if dout_if ();

  backward_lzss_decompressor_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  request_t request_q [$];
  decoded_t decoded_q [$];

  // Predictor state: parser, write pointer and its own history copy
  byte_t       flag_reg    = '0;
  bits_left_t  flags_left  = '0;
  phase_t      parse_phase = PH_FLAG;
  byte_t       token_high  = '0;
  byte_t       hist_mem [HISTORY_DEPTH];
  logic [12:0] out_ptr     = '0;

  logic        in_fire      = 1'b0;
  logic        drain_wait   = 1'b0;
  logic        holdoff_done = 1'b0;
  int unsigned holdoff_left = 0;
  int unsigned quiet_cycles = 0;

  int unsigned req_cnt    = 0;
  int unsigned byte_cnt   = 0;
  int unsigned stream_cnt = 0;
  int unsigned trunc_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned far_dist   = 0;

  wire steady_in  = (req_cnt >= 150) && (req_cnt < 260);
  wire steady_out = (byte_cnt >= 900) && (byte_cnt < 1500);

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Shift out the used flag bit; fall back to flag parsing once the group is done
  function automatic void consume_flag_bit();
    flag_reg = flag_reg << 1;
    if (flags_left != 0) flags_left--;
    parse_phase = (flags_left == 0) ? PH_FLAG : PH_ITEM;
  endfunction

  // Every produced byte lands in history and becomes one expected result
  function automatic void record_byte(byte_t v, logic run_end, logic done);
    hist_mem[out_ptr] = v;
    out_ptr++;
    decoded_q.push_back(decoded_t'{v, run_end, 1'b0, done});
  endfunction

  function automatic void decode_request(byte_t b, logic last);
    int unsigned copy_len;
    int unsigned copy_dist;
    byte_t       v;
    case (parse_phase)
      PH_FLAG: begin
        flag_reg    = b;
        flags_left  = bits_left_t'(ITEMS_PER_FLAG);
        parse_phase = PH_ITEM;
      end
      PH_ITEM: begin
        if (!flag_reg[7]) begin
          record_byte(b, 1'b1, last);
          consume_flag_bit();
        end else begin
          // First half of a copy token: hold it for the second byte
          token_high  = b;
          parse_phase = PH_TOKEN;
          if (last) begin
            decoded_q.push_back(decoded_t'{8'h00, 1'b1, 1'b1, 1'b1});
            trunc_cnt++;
          end
        end
      end
      PH_TOKEN: begin
        copy_len  = token_high[7:4] + LEN_BIAS;
        copy_dist = {token_high[3:0], b} + DIST_BIAS;
        if (copy_dist > far_dist) far_dist = copy_dist;
        // Byte by byte, so an overlapping copy re-reads what it just wrote
        for (int unsigned k = 0; k < copy_len; k++) begin
          v = hist_mem[out_ptr - 13'(copy_dist)];
          record_byte(v, k + 1 == copy_len, (k + 1 == copy_len) && last);
        end
        consume_flag_bit();
      end
      default: ;
    endcase
    // End of stream: drop leftover flag bits and rewind; history survives
    if (last) begin
      flag_reg    = '0;
      flags_left  = '0;
      parse_phase = PH_FLAG;
      token_high  = '0;
      out_ptr     = '0;
      stream_cnt++;
    end
  endfunction

  function automatic void check_decoded();
    decoded_t got;
    decoded_t want;
    got = decoded_t'{dout_if.out_byte, dout_if.run_last, dout_if.truncated,
                     dout_if.stream_done};
    byte_cnt++;
    if (decoded_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: unexpected result byte=%02h run_last=%b trunc=%b done=%b",
                 $time, got.out_byte, got.run_last, got.truncated, got.stream_done);
    end else begin
      want = decoded_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("%0t: result %0d mismatch: exp byte=%02h run_last=%b trunc=%b done=%b",
                   $time, byte_cnt, want.out_byte, want.run_last, want.truncated,
                   want.stream_done);
          $display("    got byte=%02h run_last=%b trunc=%b done=%b",
                   got.out_byte, got.run_last, got.truncated, got.stream_done);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_request(byte_t d, logic last);
    request_q.push_back(request_t'{d, last, 1'b0});
  endfunction

  // Two token bytes: length - 3 in the top nibble, distance - 3 below it
  function automatic logic [15:0] encode_copy(int unsigned len, int unsigned distance);
    return {4'(len - LEN_BIAS), 12'(distance - DIST_BIAS)};
  endfunction

  // Build one well-formed stream of n_items literals and copies. Copies only
  // reach back into bytes this stream has already produced. With cut set the
  // stream is chopped at a random byte, which may be a flag or a token half.
  task automatic build_stream(input int unsigned n_items, input int unsigned lit_pct,
                              input int unsigned long_pct, input bit cut);
    byte_t       bytes [$];
    byte_t       group [$];
    byte_t       flag;
    logic [15:0] code;
    logic        is_copy;
    int unsigned produced;
    int unsigned len;
    int unsigned distance;
    int unsigned dmax;
    int unsigned pick;
    int unsigned cut_at;
    produced = 0;
    while (n_items > 0) begin
      flag = byte_t'($urandom());
      group.delete();
      for (int i = 0; i < 8 && n_items > 0; i++) begin
        is_copy = (produced >= DIST_BIAS) && ($urandom_range(99) >= lit_pct);
        flag[7 - i] = is_copy;
        if (!is_copy) begin
          group.push_back(byte_t'($urandom()));
          produced++;
        end else begin
          len  = ($urandom_range(99) < long_pct) ? 18 : $urandom_range(LEN_BIAS, 18);
          dmax = (produced < MAX_DIST) ? produced : MAX_DIST;
          pick = $urandom_range(99);
          if (pick < 40)
            distance = $urandom_range(DIST_BIAS, (dmax < 24) ? dmax : 24);
          else if (pick < 70 || dmax < FAR_DIST)
            distance = $urandom_range(DIST_BIAS, dmax);
          else
            distance = $urandom_range(FAR_DIST, dmax);
          code = encode_copy(len, distance);
          group.push_back(code[15:8]);
          group.push_back(code[7:0]);
          produced += len;
        end
        n_items--;
      end
      bytes.push_back(flag);
      foreach (group[j]) bytes.push_back(group[j]);
    end
    if (cut) begin
      cut_at = $urandom_range(0, bytes.size() - 1);
      bytes  = bytes[0:cut_at];
    end
    foreach (bytes[i]) queue_request(bytes[i], i == bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the next queued request at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    request_t cur;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || in_fire) begin
      if (drain_wait) begin
        // Hold until every predicted byte has come out
        din_if.valid <= 1'b0;
        if (decoded_q.size() == 0) drain_wait = 1'b0;
      end else if (request_q.size() == 0 || (!steady_in && $urandom_range(99) < IDLE_PCT)) begin
        din_if.valid <= 1'b0;
      end else begin
        cur = request_q.pop_front();
        if (cur.drain) begin
          drain_wait = 1'b1;
          din_if.valid <= 1'b0;
        end else begin
          din_if.valid   <= 1'b1;
          din_if.in_byte <= cur.data;
          din_if.in_last <= cur.last;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off while input keeps
  // coming, so the block backs up and drops din.ready
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      dout_if.ready <= 1'b0;
    end else if (!holdoff_done && req_cnt >= 40) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= steady_out || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result,
  // and stop the run if the handshakes go quiet for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire <= din_if.valid && din_if.ready;
      if (din_if.valid && din_if.ready) begin
        req_cnt++;
        decode_request(din_if.in_byte, din_if.in_last);
      end
      if (dout_if.valid && dout_if.ready) check_decoded();
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, decoded_q.size());
        $display("FAIL backward_lzss_decompressor_top");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    byte_t       lits [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
    logic [15:0] code;

    din_if.valid   = 1'b0;
    din_if.in_byte = '0;
    din_if.in_last = 1'b0;
    dout_if.ready  = 1'b0;

    // Directed: eight literals under an all-clear flag, then the group rolls
    // over to a new flag byte
    queue_request(8'h00, 1'b0);
    foreach (lits[i]) queue_request(lits[i], 1'b0);
    // Shortest copy, longest copy overlapping itself, then a copy reaching
    // back to the first byte; the stream ends there with five flag bits unused
    queue_request(8'hE0, 1'b0);
    code = encode_copy(3, 3);
    queue_request(code[15:8], 1'b0);
    queue_request(code[7:0], 1'b0);
    code = encode_copy(18, 3);
    queue_request(code[15:8], 1'b0);
    queue_request(code[7:0], 1'b0);
    code = encode_copy(9, 29);
    queue_request(code[15:8], 1'b0);
    queue_request(code[7:0], 1'b1);
    // Stream that ends on its flag byte: no result at all
    queue_request(8'h3C, 1'b1);
    // Stream that ends inside a copy token: truncated marker
    queue_request(8'h10, 1'b0);
    queue_request(8'h11, 1'b0);
    queue_request(8'h22, 1'b0);
    queue_request(8'h33, 1'b0);
    queue_request(8'hC3, 1'b1);
    // Let everything drain before the random part
    request_q.push_back(request_t'{8'h00, 1'b0, 1'b1});

    // Random: short streams, some chopped at a random byte
    repeat (4) build_stream($urandom_range(2, 24), 40, 20, $urandom_range(1));
    request_q.push_back(request_t'{8'h00, 1'b0, 1'b1});
    // One long copy-heavy stream that grows past 2 KiB of output, so far
    // distances become legal
    build_stream(140, 3, 85, 1'b0);
    while (request_q.size() < 440)
      build_stream($urandom_range(1, 24), 35, 20, $urandom_range(99) < 40);

    while (request_q.size() != 0 || drain_wait || din_if.valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests in %0d streams, %0d output bytes, %0d truncated ends",
             req_cnt, stream_cnt, byte_cnt, trunc_cnt);
    $display("farthest copy distance %0d, %0d mismatches", far_dist, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS backward_lzss_decompressor_top");
    end else begin
      $display("FAIL backward_lzss_decompressor_top");
    end
    $finish;
  end

endmodule
